// ----- src/macd_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover detector: shared definitions
// Default sizes, register indices, the rebuild sequencer's state type and the
// control group that the sequencer hands to the window sum registers.
// ----------------------------------------------------------------------------
`default_nettype none

package macd_pkg;

   localparam int MAX_WINDOW_DEF = 256;
   localparam int PRICE_BITS_DEF = 20;
   localparam int NUM_WINDOWS    = 4;
   localparam int LEN_REG_BITS   = 9;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_BUY_FAST  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BUY_SLOW  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SELL_FAST = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SELL_SLOW = 2'd3;

   // Window slots, in register order.
   localparam int WIN_BUY_FAST  = 0;
   localparam int WIN_BUY_SLOW  = 1;
   localparam int WIN_SELL_FAST = 2;
   localparam int WIN_SELL_SLOW = 3;

   typedef enum logic [0:0] {
      RB_IDLE = 1'b0,
      RB_READ = 1'b1
   } rb_state_type;

   typedef struct packed {
      logic                   busy;
      logic                   rd_en;
      logic                   clear;
      logic [NUM_WINDOWS-1:0] acc_mask;
   } rb_ctl_type;

endpackage

`default_nettype wire

// ----- src/moving_average_crossover_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover detector
// Dual simple moving average crossover on a stream of price samples.
// ----------------------------------------------------------------------------
// The unit takes one price item per clock cycle while neither the result
// side stalls nor a rebuild runs, and returns one result item per price
// through the price, sum, product and result registers. Four running window
// sums are kept, each updated by one add and one subtract per item against
// the sample leaving its window, which is read from one copy of the price
// ring per window. Writing a length register starts a rebuild that walks the
// whole ring through a single read port and recomputes all four sums; no
// price item is taken while it runs. No clearing pass follows reset: the
// fill count masks ring entries that have not been written yet.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_crossover_detector_unit #(
   parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF,
   parameter int PRICE_BITS = macd_pkg::PRICE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [PRICE_BITS-1:0]               req_price,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_golden_cross,
   output logic                                     rsp_death_cross,
   output logic                                     rsp_warm,
   input  wire logic                                csr_we,
   input  wire logic [macd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [macd_pkg::LEN_REG_BITS-1:0]   csr_wdata
);

   localparam int NW = macd_pkg::NUM_WINDOWS;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int CW = (LW > macd_pkg::LEN_REG_BITS) ? LW : macd_pkg::LEN_REG_BITS;
   localparam int SW = PRICE_BITS + AW;

   logic [NW-1:0][macd_pkg::LEN_REG_BITS-1:0] len_reg_ff;
   logic [NW-1:0][LW-1:0]         len_eff;
   logic [NW-1:0][CW-1:0]         len_wide;
   logic [LW-1:0]                 need_a, need_b, need;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [LW-1:0]                 fill_ff, fill_in;
   logic                          accept;
   logic                          v1_ff, v1_in, v2_ff, v2_in;
   logic                          mv1, s1_free, s2_free, take2;
   logic [PRICE_BITS-1:0]         price1_ff;
   logic [NW-1:0]                 ok1_ff;
   logic                          warm1_ff, warm2_ff;
   logic [NW-1:0][AW:0]           back_sum;
   logic [NW-1:0][AW-1:0]         back_addr, raddr;
   logic [NW-1:0][PRICE_BITS-1:0] leave;
   logic [NW-1:0][SW-1:0]         sums;
   logic [AW-1:0]                 rb_addr;
   macd_pkg::rb_ctl_type          rb_ctl;

   // Length registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            len_reg_ff[i] <= macd_pkg::LEN_REG_BITS'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            macd_pkg::REG_BUY_FAST:  len_reg_ff[macd_pkg::WIN_BUY_FAST]  <= csr_wdata;
            macd_pkg::REG_BUY_SLOW:  len_reg_ff[macd_pkg::WIN_BUY_SLOW]  <= csr_wdata;
            macd_pkg::REG_SELL_FAST: len_reg_ff[macd_pkg::WIN_SELL_FAST] <= csr_wdata;
            macd_pkg::REG_SELL_SLOW: len_reg_ff[macd_pkg::WIN_SELL_SLOW] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A length of zero counts as one; lengths beyond the ring count as its depth.
   always_comb begin
      for (int i = 0; i < NW; i++) begin
         len_wide[i] = CW'(len_reg_ff[i]);
         if (len_wide[i] == '0) begin
            len_eff[i] = LW'(1);
         end else if (len_wide[i] > CW'(MAX_WINDOW)) begin
            len_eff[i] = LW'(MAX_WINDOW);
         end else begin
            len_eff[i] = LW'(len_wide[i]);
         end
      end
   end

   assign need_a = (len_eff[0] > len_eff[1]) ? len_eff[0] : len_eff[1];
   assign need_b = (len_eff[2] > len_eff[3]) ? len_eff[2] : len_eff[3];
   assign need   = (need_a > need_b) ? need_a : need_b;

   // Handshake chain through the price register and the sum registers.
   assign s2_free   = !v2_ff || take2;
   assign mv1       = v1_ff && s2_free;
   assign s1_free   = !v1_ff || mv1;
   assign req_ready = s1_free && !rb_ctl.busy;
   assign accept    = req_valid && req_ready;

   assign v1_in = accept ? 1'b1 : (mv1 ? 1'b0 : v1_ff);
   assign v2_in = mv1 ? 1'b1 : (take2 ? 1'b0 : v2_ff);

   assign ptr_in  = (ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : ptr_ff + AW'(1);
   assign fill_in = (fill_ff < LW'(MAX_WINDOW)) ? fill_ff + LW'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         ptr_ff  <= '0;
         fill_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         if (accept) begin
            ptr_ff  <= ptr_in;
            fill_ff <= fill_in;
         end
      end
   end

   // The leaving sample sits len entries back; it exists only once written.
   always_ff @(posedge clock) begin
      if (accept) begin
         price1_ff <= req_price;
         warm1_ff  <= (fill_in >= need);
         for (int i = 0; i < NW; i++) begin
            ok1_ff[i] <= (len_eff[i] <= fill_ff);
         end
      end
      if (mv1) begin
         warm2_ff <= warm1_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         back_sum[i]  = {1'b0, ptr_ff} + (AW+1)'(MAX_WINDOW) - (AW+1)'(len_eff[i]);
         back_addr[i] = (back_sum[i] >= (AW+1)'(MAX_WINDOW))
                        ? AW'(back_sum[i] - (AW+1)'(MAX_WINDOW)) : AW'(back_sum[i]);
         raddr[i]     = rb_ctl.rd_en ? rb_addr : back_addr[i];
      end
   end

   // One copy of the ring per window, all written with the same sample.
   for (genvar g = 0; g < NW; g++) begin : g_ring
      macd_ram #(
         .WIDTH (PRICE_BITS),
         .DEPTH (MAX_WINDOW)
      ) u_ring (
         .clock (clock),
         .we    (accept),
         .waddr (ptr_ff),
         .wdata (req_price),
         .re    (accept || rb_ctl.rd_en),
         .raddr (raddr[g]),
         .rdata (leave[g])
      );
   end

   macd_rebuild #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_rebuild (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_we),
      .ptr     (ptr_ff),
      .len_eff (len_eff),
      .fill    (fill_ff),
      .ctl     (rb_ctl),
      .rd_addr (rb_addr)
   );

   macd_window #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rb_ctl),
      .upd      (mv1),
      .price    (price1_ff),
      .leave    (leave),
      .leave_ok (ok1_ff),
      .sums     (sums)
   );

   macd_compare #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_compare (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (v2_ff),
      .in_take          (take2),
      .in_warm          (warm2_ff),
      .sums             (sums),
      .len_eff          (len_eff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_golden_cross (rsp_golden_cross),
      .rsp_death_cross  (rsp_death_cross),
      .rsp_warm         (rsp_warm)
   );

endmodule

`default_nettype wire

// ----- src/macd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic                                      re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/macd_rebuild.sv -----
// ----------------------------------------------------------------------------
// Window sum rebuild sequencer
// After a length register is written, walks the price ring from the newest
// sample backwards, one entry a cycle, and tells the sum registers which
// windows each returned sample belongs to.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_rebuild #(
   parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             start,
   input  wire logic [$clog2(MAX_WINDOW)-1:0]                    ptr,
   input  wire logic [macd_pkg::NUM_WINDOWS-1:0][$clog2(MAX_WINDOW+1)-1:0] len_eff,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                  fill,
   output macd_pkg::rb_ctl_type                                  ctl,
   output logic      [$clog2(MAX_WINDOW)-1:0]                    rd_addr
);

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int LW = $clog2(MAX_WINDOW + 1);

   macd_pkg::rb_state_type state_ff, state_in;
   logic [AW-1:0] k_ff, k_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_k_ff;
   logic [AW:0]   addr_sum;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         macd_pkg::RB_IDLE: begin
            if (start) begin
               state_in = macd_pkg::RB_READ;
            end
         end
         macd_pkg::RB_READ: begin
            if (start) begin
               state_in = macd_pkg::RB_READ;
            end else if (k_ff == AW'(MAX_WINDOW - 1)) begin
               state_in = macd_pkg::RB_IDLE;
            end
         end
         default: state_in = macd_pkg::RB_IDLE;
      endcase
   end

   always_comb begin
      k_in = k_ff;
      if (start) begin
         k_in = '0;
      end else if (state_ff == macd_pkg::RB_READ) begin
         k_in = k_ff + AW'(1);
      end
   end

   // A read in flight when the walk restarts belongs to the old lengths.
   assign pend_in = (state_ff == macd_pkg::RB_READ) && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= macd_pkg::RB_IDLE;
         k_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_k_ff <= k_ff;
   end

   always_comb begin
      ctl.busy  = (state_ff != macd_pkg::RB_IDLE) || pend_ff || start;
      ctl.rd_en = (state_ff == macd_pkg::RB_READ);
      ctl.clear = start;
      for (int i = 0; i < macd_pkg::NUM_WINDOWS; i++) begin
         ctl.acc_mask[i] = pend_ff && !start && (LW'(pend_k_ff) < len_eff[i])
                           && (LW'(pend_k_ff) < fill);
      end
   end

   // Entry k back from the newest sample: (ptr - 1 - k) modulo the ring depth.
   assign addr_sum = {1'b0, ptr} + (AW+1)'(MAX_WINDOW - 1) - {1'b0, k_ff};
   assign rd_addr  = (addr_sum >= (AW+1)'(MAX_WINDOW))
                     ? AW'(addr_sum - (AW+1)'(MAX_WINDOW)) : AW'(addr_sum);

endmodule

`default_nettype wire

// ----- src/macd_window.sv -----
// ----------------------------------------------------------------------------
// Window sum registers
// Four running sums: each item adds the new sample and takes away the one
// that leaves its window; a rebuild clears them and adds the ring back in.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_window #(
   parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF,
   parameter int PRICE_BITS = macd_pkg::PRICE_BITS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire macd_pkg::rb_ctl_type                          ctl,
   input  wire logic                                          upd,
   input  wire logic [PRICE_BITS-1:0]                         price,
   input  wire logic [macd_pkg::NUM_WINDOWS-1:0][PRICE_BITS-1:0] leave,
   input  wire logic [macd_pkg::NUM_WINDOWS-1:0]              leave_ok,
   output logic [macd_pkg::NUM_WINDOWS-1:0][PRICE_BITS+$clog2(MAX_WINDOW)-1:0] sums
);

   localparam int SW = PRICE_BITS + $clog2(MAX_WINDOW);

   logic [macd_pkg::NUM_WINDOWS-1:0][SW-1:0] sums_ff, sums_in;

   // Intermediate sums may wrap; the result of add and subtract always fits.
   always_comb begin
      for (int i = 0; i < macd_pkg::NUM_WINDOWS; i++) begin
         sums_in[i] = sums_ff[i];
         if (ctl.clear) begin
            sums_in[i] = '0;
         end else if (ctl.acc_mask[i]) begin
            sums_in[i] = sums_ff[i] + SW'(leave[0]);
         end else if (upd) begin
            sums_in[i] = sums_ff[i] + SW'(price)
                         - (leave_ok[i] ? SW'(leave[i]) : SW'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

`default_nettype wire

// ----- src/macd_compare.sv -----
// ----------------------------------------------------------------------------
// Cross-multiplied average compare and result register
// Registers the four cross products, compares them, tracks the previous
// item's direction and warm flags and holds the result item for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_compare #(
   parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF,
   parameter int PRICE_BITS = macd_pkg::PRICE_BITS_DEF
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            in_valid,
   output logic                                                 in_take,
   input  wire logic                                            in_warm,
   input  wire logic [macd_pkg::NUM_WINDOWS-1:0][PRICE_BITS+$clog2(MAX_WINDOW)-1:0] sums,
   input  wire logic [macd_pkg::NUM_WINDOWS-1:0][$clog2(MAX_WINDOW+1)-1:0] len_eff,
   output logic                                                 rsp_valid,
   input  wire logic                                            rsp_ready,
   output logic                                                 rsp_golden_cross,
   output logic                                                 rsp_death_cross,
   output logic                                                 rsp_warm
);

   localparam int SW = PRICE_BITS + $clog2(MAX_WINDOW);
   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int PW = SW + LW;

   logic          v3_ff, v3_in;
   logic          warm3_ff;
   logic [PW-1:0] buy_fast_ff, buy_slow_ff, sell_fast_ff, sell_slow_ff;
   logic          out_free, mv3, s3_free;
   logic          buy_below, buy_above, sell_below, sell_above;
   logic          golden, death;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          golden_ff, death_ff, warm_ff;
   logic          prev_buy_below_ff, prev_sell_above_ff, prev_warm_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mv3      = v3_ff && out_free;
   assign s3_free  = !v3_ff || mv3;
   assign in_take  = in_valid && s3_free;

   assign v3_in        = in_take ? 1'b1 : (mv3 ? 1'b0 : v3_ff);
   assign rsp_valid_in = mv3 ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Each average is compared as its sum times the other window's length.
   always_ff @(posedge clock) begin
      if (in_take) begin
         buy_fast_ff  <= PW'(sums[macd_pkg::WIN_BUY_FAST]) * PW'(len_eff[macd_pkg::WIN_BUY_SLOW]);
         buy_slow_ff  <= PW'(sums[macd_pkg::WIN_BUY_SLOW]) * PW'(len_eff[macd_pkg::WIN_BUY_FAST]);
         sell_fast_ff <= PW'(sums[macd_pkg::WIN_SELL_FAST])
                         * PW'(len_eff[macd_pkg::WIN_SELL_SLOW]);
         sell_slow_ff <= PW'(sums[macd_pkg::WIN_SELL_SLOW])
                         * PW'(len_eff[macd_pkg::WIN_SELL_FAST]);
         warm3_ff     <= in_warm;
      end
   end

   assign buy_below  = buy_fast_ff < buy_slow_ff;
   assign buy_above  = buy_fast_ff > buy_slow_ff;
   assign sell_below = sell_fast_ff < sell_slow_ff;
   assign sell_above = sell_fast_ff > sell_slow_ff;

   assign golden = warm3_ff && prev_warm_ff && prev_buy_below_ff && buy_above;
   assign death  = warm3_ff && prev_warm_ff && prev_sell_above_ff && sell_below;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff              <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         prev_buy_below_ff  <= 1'b0;
         prev_sell_above_ff <= 1'b0;
         prev_warm_ff       <= 1'b0;
      end else begin
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mv3) begin
            prev_buy_below_ff  <= buy_below;
            prev_sell_above_ff <= sell_above;
            prev_warm_ff       <= warm3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv3) begin
         golden_ff <= golden;
         death_ff  <= death;
         warm_ff   <= warm3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_golden_cross = golden_ff;
   assign rsp_death_cross  = death_ff;
   assign rsp_warm         = warm_ff;

endmodule

`default_nettype wire

// ----- verif/macd_crossover_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average crossover checker
// Watches the price, result and register ports of the crossover unit, keeps
// its own price history and window lengths, predicts the cross flags of every
// accepted price item and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module macd_crossover_checker
   import macd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [PRICE_BITS_DEF-1:0] req_price,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic                      rsp_golden_cross,
   input  wire logic                      rsp_death_cross,
   input  wire logic                      rsp_warm,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [LEN_REG_BITS-1:0]   csr_wdata,
   output int                             pending,
   output int                             errors
);

   typedef struct packed {
      logic golden_cross;
      logic death_cross;
      logic warm;
   } cross_flags_type;

   logic [PRICE_BITS_DEF-1:0] price_hist [MAX_WINDOW_DEF];
   int                        hist_wr;
   int                        samples_seen;
   logic [LEN_REG_BITS-1:0]   len_cfg [NUM_WINDOWS];
   logic                      was_buy_below;
   logic                      was_sell_above;
   logic                      was_warm;
   cross_flags_type           flags_due [$];
   cross_flags_type           fresh;
   cross_flags_type           want;
   int                        err_count;

   function automatic int clamp_len(input logic [LEN_REG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return int'(v);
   endfunction

   function automatic logic [63:0] newest_total(input int n);
      logic [63:0] acc;
      int          k;
      acc = '0;
      for (k = 0; k < n; k++)
         acc += price_hist[(hist_wr + MAX_WINDOW_DEF - 1 - k) % MAX_WINDOW_DEF];
      return acc;
   endfunction

   // Stores the price, re-forms every window sum from the history and
   // compares the averages by cross-multiplying with the other window's length.
   task automatic take_price(input logic [PRICE_BITS_DEF-1:0] p,
                             output cross_flags_type f);
      int          span [NUM_WINDOWS];
      logic [63:0] total [NUM_WINDOWS];
      int          need;
      int          w;
      logic        warm_now;
      logic        buy_below;
      logic        buy_above;
      logic        sell_below;
      logic        sell_above;
      price_hist[hist_wr] = p;
      hist_wr = (hist_wr + 1) % MAX_WINDOW_DEF;
      if (samples_seen < MAX_WINDOW_DEF) samples_seen++;
      need = 0;
      for (w = 0; w < NUM_WINDOWS; w++) begin
         span[w] = clamp_len(len_cfg[w]);
         total[w] = newest_total(span[w]);
         if (span[w] > need) need = span[w];
      end
      warm_now = samples_seen >= need;
      buy_below  = total[WIN_BUY_FAST] * span[WIN_BUY_SLOW]
                 < total[WIN_BUY_SLOW] * span[WIN_BUY_FAST];
      buy_above  = total[WIN_BUY_FAST] * span[WIN_BUY_SLOW]
                 > total[WIN_BUY_SLOW] * span[WIN_BUY_FAST];
      sell_below = total[WIN_SELL_FAST] * span[WIN_SELL_SLOW]
                 < total[WIN_SELL_SLOW] * span[WIN_SELL_FAST];
      sell_above = total[WIN_SELL_FAST] * span[WIN_SELL_SLOW]
                 > total[WIN_SELL_SLOW] * span[WIN_SELL_FAST];
      f.golden_cross = warm_now && was_warm && was_buy_below && buy_above;
      f.death_cross  = warm_now && was_warm && was_sell_above && sell_below;
      f.warm         = warm_now;
      was_buy_below  = buy_below;
      was_sell_above = sell_above;
      was_warm       = warm_now;
   endtask

   task automatic note_mismatch(input string field, input logic exp_v, input logic act_v);
      err_count++;
      $error("%s: expected %0b, got %0b", field, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (price_hist[i]) price_hist[i] = '0;
         foreach (len_cfg[i]) len_cfg[i] = LEN_REG_BITS'(1);
         hist_wr        = 0;
         samples_seen   = 0;
         was_buy_below  = 1'b0;
         was_sell_above = 1'b0;
         was_warm       = 1'b0;
         err_count      = 0;
         flags_due.delete();
      end else begin
         if (csr_we) len_cfg[csr_index] = csr_wdata;
         if (req_valid && req_ready) begin
            take_price(req_price, fresh);
            flags_due.push_back(fresh);
         end
         if (rsp_valid && rsp_ready) begin
            if (flags_due.size() == 0) begin
               err_count++;
               $error("result item arrived with no price item outstanding");
            end else begin
               want = flags_due.pop_front();
               if (rsp_golden_cross !== want.golden_cross)
                  note_mismatch("golden_cross", want.golden_cross, rsp_golden_cross);
               if (rsp_death_cross !== want.death_cross)
                  note_mismatch("death_cross", want.death_cross, rsp_death_cross);
               if (rsp_warm !== want.warm)
                  note_mismatch("warm", want.warm, rsp_warm);
            end
         end
      end
      pending <= flags_due.size();
      errors  <= err_count;
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average crossover detector testbench
// Drives price items and window length writes into the crossover unit with
// random gaps and stalls on both channels; a checker beside the unit predicts
// and compares every result item. Directed extremes come first, then trending
// price walks with noise under a series of window settings.
// ----------------------------------------------------------------------------
module tb;
   import macd_pkg::*;

   localparam int ITEMS = 1850;
   localparam logic [PRICE_BITS_DEF-1:0] PRICE_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [PRICE_BITS_DEF-1:0] req_price;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_golden_cross;
   logic                      rsp_death_cross;
   logic                      rsp_warm;
   logic                      csr_we;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [LEN_REG_BITS-1:0]   csr_wdata;
   int                        pending;
   int                        errors;

   int item_no;
   int snd_idle_pct;
   int rsp_idle_pct;
   int lvl;
   int drift;
   int amp;
   int seg_left;

   moving_average_crossover_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_golden_cross (rsp_golden_cross),
      .rsp_death_cross  (rsp_death_cross),
      .rsp_warm         (rsp_warm),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   macd_crossover_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_golden_cross (rsp_golden_cross),
      .rsp_death_cross  (rsp_death_cross),
      .rsp_warm         (rsp_warm),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending          (pending),
      .errors           (errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Offers one price item and returns at the edge where it is taken.
   task automatic send_price(input logic [PRICE_BITS_DEF-1:0] p);
      if (item_no < ITEMS / 3) begin
         snd_idle_pct = 30;
         rsp_idle_pct = 73;
      end else if (item_no < 2 * ITEMS / 3) begin
         snd_idle_pct = 73;
         rsp_idle_pct = 30;
      end else begin
         snd_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_no++;
   endtask

   // Holds the price channel quiet until every outstanding result has come.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_len(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [LEN_REG_BITS-1:0] val);
      drain();
      // A length write starts a rebuild over the whole ring; let any earlier
      // one finish before the next write.
      repeat (MAX_WINDOW_DEF + 8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_windows(input logic [LEN_REG_BITS-1:0] bf, input logic [LEN_REG_BITS-1:0] bs,
                              input logic [LEN_REG_BITS-1:0] sf, input logic [LEN_REG_BITS-1:0] ss);
      write_len(REG_BUY_FAST, bf);
      write_len(REG_BUY_SLOW, bs);
      write_len(REG_SELL_FAST, sf);
      write_len(REG_SELL_SLOW, ss);
   endtask

   function automatic logic [LEN_REG_BITS-1:0] pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1)
         return LEN_REG_BITS'($urandom_range(MAX_WINDOW_DEF + 1, (1 << LEN_REG_BITS) - 1));
      if (r == 2) return LEN_REG_BITS'(MAX_WINDOW_DEF);
      if (r < 7) return LEN_REG_BITS'($urandom_range(1, 16));
      return LEN_REG_BITS'($urandom_range(17, MAX_WINDOW_DEF - 1));
   endfunction

   // Trending walk in segments of random slope and noise, with flat stretches
   // for ties and the odd full-range or extreme sample thrown in.
   task automatic next_price(output logic [PRICE_BITS_DEF-1:0] p);
      int roll;
      if (seg_left == 0) begin
         seg_left = int'($urandom_range(3, 120));
         if ($urandom_range(0, 9) == 0) begin
            drift = 0;
            amp   = 0;
         end else begin
            drift = int'($urandom_range(0, 8000)) - 4000;
            amp   = int'($urandom_range(0, 30000));
         end
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         p = PRICE_BITS_DEF'($urandom_range(0, PRICE_MAX));
      end else if (roll < 10) begin
         p = roll[0] ? PRICE_MAX : '0;
      end else begin
         lvl += drift + int'($urandom_range(0, 2 * amp)) - amp;
         if (lvl < 0) begin
            lvl   = 0;
            drift = -drift;
         end
         if (lvl > int'(PRICE_MAX)) begin
            lvl   = int'(PRICE_MAX);
            drift = -drift;
         end
         p = lvl[PRICE_BITS_DEF-1:0];
      end
   endtask

   initial begin
      int                        phase;
      int                        seg;
      int                        i;
      logic [PRICE_BITS_DEF-1:0] p;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_price    = '0;
      csr_we       = 1'b0;
      csr_index    = REG_BUY_FAST;
      csr_wdata    = '0;
      item_no      = 0;
      snd_idle_pct = 30;
      rsp_idle_pct = 73;
      lvl          = 500000;
      drift        = 0;
      amp          = 0;
      seg_left     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every window one sample long: fast always equals slow, so no cross.
      send_price('0);
      send_price(PRICE_MAX);
      send_price('0);

      // A zero length reads as one; one-against-two windows cross whenever the
      // price turns, and flat prices give ties that neither start nor end one.
      set_windows(0, 2, 1, 2);
      send_price(PRICE_MAX);
      send_price('0);
      send_price(PRICE_MAX);
      send_price('0);
      send_price('0);
      send_price(PRICE_MAX);
      send_price(1);
      send_price(2);
      send_price(1);

      // Oversized lengths clamp to the full ring, so nothing is warm for a while.
      set_windows(1, 511, 257, 1);
      send_price(PRICE_MAX);
      send_price('0);
      repeat (6) send_price(PRICE_BITS_DEF'($urandom_range(0, PRICE_MAX)));

      phase = 0;
      while (item_no < ITEMS) begin
         case (phase)
            0: ;
            1: set_windows(256, 256, 256, 256);
            2: set_windows(256, 1, 1, 256);
            3: set_windows(0, 0, 511, 511);
            default: set_windows(pick_len(), pick_len(), pick_len(), pick_len());
         endcase
         seg = (phase == 0) ? 400 : $urandom_range(80, 160);
         for (i = 0; i < seg && item_no < ITEMS; i++) begin
            if (phase == 5 && i == seg / 2) drain();
            next_price(p);
            send_price(p);
         end
         phase++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/macd_pkg.sv
src/macd_ram.sv
src/macd_rebuild.sv
src/macd_window.sv
src/macd_compare.sv
src/moving_average_crossover_detector_unit.sv
verif/macd_crossover_checker.sv
verif/tb.sv
